/* src/can_tx_slot_alloc_and_header_pack_top_assert.svh */
// ----------------------------------------------------------------------------
// can_tx_slot_alloc_and_header_pack_top_assert
// assertion macros used by the transmit slot allocator slot pool
// ----------------------------------------------------------------------------
`ifndef CAN_TX_SLOT_ALLOC_AND_HEADER_PACK_TOP_ASSERT_SVH
`define CAN_TX_SLOT_ALLOC_AND_HEADER_PACK_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define CTXSA_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define CTXSA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/ctxsa_pkg.sv */
// ----------------------------------------------------------------------------
// ctxsa_pkg
// shared types and constants for the transmit slot allocator
// ----------------------------------------------------------------------------
package ctxsa_pkg;

    localparam int SLOT_COUNT = 20;
    localparam int SLOT_IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int COUNT_W    = $clog2(SLOT_COUNT + 1);

    localparam int ID_W       = 29;
    localparam int LEN_W      = 4;
    localparam int SLOT_W     = 5;
    localparam int WORD_W     = 16;
    localparam int LENB_W     = 7;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 56;

    localparam logic [LEN_W-1:0] MAX_LEN = 4'd8;

    typedef enum logic {
        ACT_SUBMIT  = 1'b0,
        ACT_RELEASE = 1'b1
    } action_t;

    typedef struct packed {
        logic              go;
        action_t           action;
        logic [SLOT_W-1:0] rel_slot;
    } pool_req_t;

    typedef struct packed {
        logic                  accepted;
        logic [SLOT_IDX_W-1:0] slot;
        logic                  stopped;
        logic [COUNT_W-1:0]    free;
        logic                  rel_err;
    } pool_rsp_t;

endpackage

/* src/ctxsa_hdr_pack.sv */
// ----------------------------------------------------------------------------
// ctxsa_hdr_pack
// packs the can identifier into sid/eid words and forms the length byte
// ----------------------------------------------------------------------------
module ctxsa_hdr_pack (
    input  logic [ctxsa_pkg::ID_W-1:0]   frame_id,
    input  logic                         extended,
    input  logic                         remote,
    input  logic [ctxsa_pkg::LEN_W-1:0]  frame_length,
    output logic [ctxsa_pkg::WORD_W-1:0] sid_word,
    output logic [ctxsa_pkg::WORD_W-1:0] eid_word,
    output logic [ctxsa_pkg::LENB_W-1:0] length_byte
);
    import ctxsa_pkg::*;

    logic [LEN_W-1:0] len_sat;

    always_comb begin
        if (extended) begin
            sid_word = {frame_id[28:18], 1'b0, 1'b1, 1'b0, frame_id[17:16]};
            eid_word = frame_id[15:0];
        end else begin
            sid_word = {frame_id[10:0], 5'b0};
            eid_word = '0;
        end
        len_sat     = (frame_length > MAX_LEN) ? MAX_LEN : frame_length;
        length_byte = {remote, 2'b0, len_sat};
    end

endmodule

/* src/ctxsa_slot_pool.sv */
// ----------------------------------------------------------------------------
// ctxsa_slot_pool
// slot busy flags, free count and stopped flag with lowest-free-slot pick
// ----------------------------------------------------------------------------
`include "can_tx_slot_alloc_and_header_pack_top_assert.svh"

module ctxsa_slot_pool (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  ctxsa_pkg::pool_req_t req,
    output ctxsa_pkg::pool_rsp_t rsp
);
    import ctxsa_pkg::*;

    logic [SLOT_COUNT-1:0] slot_busy_reg, slot_busy_next;
    logic [COUNT_W-1:0]    free_count_reg, free_count_next;
    logic                  stopped_reg, stopped_next;

    logic                  pick_found;
    logic [SLOT_IDX_W-1:0] pick_idx;
    logic [SLOT_IDX_W-1:0] rel_idx;
    logic                  rel_in_range;

    // lowest free slot
    always_comb begin
        pick_found = 1'b0;
        pick_idx   = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (!slot_busy_reg[i]) begin
                pick_found = 1'b1;
                pick_idx   = SLOT_IDX_W'(i);
            end
        end
    end

    assign rel_idx      = SLOT_IDX_W'(req.rel_slot);
    assign rel_in_range = 32'(req.rel_slot) < SLOT_COUNT;

    always_comb begin
        slot_busy_next  = slot_busy_reg;
        free_count_next = free_count_reg;
        stopped_next    = stopped_reg;
        rsp             = '0;
        if (req.go) begin
            if (req.action == ACT_SUBMIT) begin
                if (pick_found) begin
                    slot_busy_next[pick_idx] = 1'b1;
                    if (free_count_reg != '0) begin
                        free_count_next = free_count_reg - 1'b1;
                    end
                    rsp.accepted = 1'b1;
                    rsp.slot     = pick_idx;
                end
                if (free_count_next == '0) begin
                    stopped_next = 1'b1;
                end
            end else if (rel_in_range) begin
                if (slot_busy_reg[rel_idx]) begin
                    slot_busy_next[rel_idx] = 1'b0;
                    if (free_count_reg < COUNT_W'(SLOT_COUNT)) begin
                        free_count_next = free_count_reg + 1'b1;
                    end
                    stopped_next = 1'b0;
                    rsp.accepted = 1'b1;
                end else begin
                    rsp.rel_err = 1'b1;
                end
            end
        end
        rsp.stopped = stopped_next;
        rsp.free    = free_count_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_busy_reg  <= '0;
            free_count_reg <= COUNT_W'(SLOT_COUNT);
            stopped_reg    <= 1'b0;
        end else begin
            slot_busy_reg  <= slot_busy_next;
            free_count_reg <= free_count_next;
            stopped_reg    <= stopped_next;
        end
    end

    `CTXSA_ASSERT_IMPL(a_count_matches_busy, 1'b1,
        ($countones(slot_busy_reg) + int'(free_count_reg)) == SLOT_COUNT,
        "free count disagrees with busy flags")
    `CTXSA_ASSERT_IMPL(a_stopped_only_when_full, stopped_reg,
        free_count_reg == '0, "queue stopped with free slots left")
    `CTXSA_ASSERT_NEXT(a_bad_release_no_change, req.go && rsp.rel_err,
        $stable(slot_busy_reg) && $stable(free_count_reg),
        "rejected release changed the pool")
    `CTXSA_ASSERT_IMPL(a_grant_only_free, req.go && (req.action == ACT_SUBMIT) && rsp.accepted,
        !slot_busy_reg[rsp.slot], "granted slot was already busy")

endmodule

/* src/can_tx_slot_alloc_and_header_pack_top.sv */
// ----------------------------------------------------------------------------
// can_tx_slot_alloc_and_header_pack_top
// transmit slot allocator with can header packing, stream in and out
// ----------------------------------------------------------------------------
// registers: input reg, then result reg, between input transaction and result on m_axis
// throughput: one transaction per cycle while m_axis is not stalled; pick and packing sit between the two registers
// a stalled result register holds one item and the input register a second one
// reset: synchronous, aresetn low; all 20 slots free, free count 20, queue not stopped
module can_tx_slot_alloc_and_header_pack_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // frame_id[28:0], extended[29], remote[30], frame_length[34:31], release_slot[39:35]
    input  logic [ctxsa_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // action[0]
    input  logic [0:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // accepted[0], granted_slot[5:1], sid_word[21:6], eid_word[37:22],
    // length_byte[44:38], queue_stopped[45], free_slots[50:46], release_error[51], zero[55:52]
    output logic [ctxsa_pkg::M_TDATA_W-1:0] m_axis_tdata
);
    import ctxsa_pkg::*;

    logic                  in_valid_reg;
    action_t               action_reg;
    logic [ID_W-1:0]       frame_id_reg;
    logic                  extended_reg;
    logic                  remote_reg;
    logic [LEN_W-1:0]      frame_length_reg;
    logic [SLOT_W-1:0]     release_slot_reg;

    logic                  out_valid_reg;
    logic [M_TDATA_W-1:0]  out_data_reg, out_data_next;

    logic                  advance;
    logic                  granted;
    pool_req_t             pool_req;
    pool_rsp_t             pool_rsp;
    logic [WORD_W-1:0]     sid_raw, eid_raw;
    logic [LENB_W-1:0]     lenb_raw;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            action_reg       <= action_t'(s_axis_tuser[0]);
            frame_id_reg     <= s_axis_tdata[28:0];
            extended_reg     <= s_axis_tdata[29];
            remote_reg       <= s_axis_tdata[30];
            frame_length_reg <= s_axis_tdata[34:31];
            release_slot_reg <= s_axis_tdata[39:35];
        end
    end

    assign pool_req.go       = advance;
    assign pool_req.action   = action_reg;
    assign pool_req.rel_slot = release_slot_reg;

    ctxsa_slot_pool u_pool (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (pool_req),
        .rsp     (pool_rsp)
    );

    ctxsa_hdr_pack u_hdr (
        .frame_id     (frame_id_reg),
        .extended     (extended_reg),
        .remote       (remote_reg),
        .frame_length (frame_length_reg),
        .sid_word     (sid_raw),
        .eid_word     (eid_raw),
        .length_byte  (lenb_raw)
    );

    assign granted = pool_rsp.accepted && (action_reg == ACT_SUBMIT);

    always_comb begin
        out_data_next        = '0;
        out_data_next[0]     = pool_rsp.accepted;
        out_data_next[5:1]   = granted ? SLOT_W'(pool_rsp.slot) : '0;
        out_data_next[21:6]  = granted ? sid_raw : '0;
        out_data_next[37:22] = granted ? eid_raw : '0;
        out_data_next[44:38] = granted ? lenb_raw : '0;
        out_data_next[45]    = pool_rsp.stopped;
        out_data_next[50:46] = SLOT_W'(pool_rsp.free);
        out_data_next[51]    = pool_rsp.rel_err;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_axis_tready) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule
